// ===== sv/fp32_isclose_comparator_core_macros.svh =====
// assertion macros used by the comparator core module
`ifndef FP32_ISCLOSE_COMPARATOR_CORE_MACROS_SVH
`define FP32_ISCLOSE_COMPARATOR_CORE_MACROS_SVH

// check a property on the main clock, idle during reset
`define FIC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// a condition in one cycle implies an outcome in the next
`define FIC_ASSERT_NEXT(name, cond, outcome, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (outcome)) \
      else $error(msg);

`endif

// ===== sv/fic_pkg.sv =====
// shared types, codes and helper functions of the fp32 closeness comparator
package fic_pkg;

   localparam logic [1:0] CSR_REL_TOLERANCE  = 2'd0;
   localparam logic [1:0] CSR_ABS_TOLERANCE  = 2'd1;
   localparam logic [1:0] CSR_NAN_EQUAL_MODE = 2'd2;

   localparam logic [31:0] REL_TOLERANCE_RESET = 32'h3727C5AC;
   localparam logic [31:0] ABS_TOLERANCE_RESET = 32'h322BCC77;
   localparam logic        NAN_EQUAL_RESET     = 1'b1;

   localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
   localparam logic [7:0]  EXP_ONES  = 8'hFF;

   // decision made from the operands and tolerance settings, before any arithmetic
   typedef enum logic [1:0] {
      EARLY_NONE,
      EARLY_CLOSE,
      EARLY_FAR
   } fic_early_type;

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] cnt;
      cnt = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) cnt = 5'(26 - i);
      end
      return cnt;
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] cnt;
      cnt = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) cnt = 6'(47 - i);
      end
      return cnt;
   endfunction

   function automatic logic is_nan(input logic [31:0] u);
      return (u[30:23] == EXP_ONES) && (u[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] u);
      return (u[30:23] == EXP_ONES) && (u[22:0] == 23'd0);
   endfunction

endpackage

// ===== sv/fic_add_unit.sv =====
// two-stage fp32 adder: align and add, then normalize and round to nearest even
module fic_add_unit (
   input  logic        clock,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic        sub,
   input  logic        en_a,
   input  logic        en_b,
   output logic [31:0] z
);

   logic        sign_ff, sign_in;
   logic [7:0]  exp_ff, exp_in;
   logic [27:0] sum_ff, sum_in;
   logic        nan_ff, nan_in;
   logic        inf_ff, inf_in;
   logic        isign_ff, isign_in;
   logic [31:0] z_ff, z_in;

   always_comb begin
      logic [31:0] yb, lg, sm;
      logic [7:0]  el, es, d;
      logic [4:0]  dc;
      logic [26:0] ml;
      logic [31:0] ms, shd, mask;
      logic [26:0] yal;
      logic        xi, yi;
      yb   = {y[31] ^ sub, y[30:0]};
      xi   = fic_pkg::is_inf(x);
      yi   = fic_pkg::is_inf(yb);
      nan_in = fic_pkg::is_nan(x) || fic_pkg::is_nan(yb) || (xi && yi && (x[31] != yb[31]));
      inf_in = (xi || yi) && !nan_in;
      isign_in = xi ? x[31] : yb[31];
      if (x[30:0] >= yb[30:0]) begin
         lg = x;
         sm = yb;
      end else begin
         lg = yb;
         sm = x;
      end
      el   = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
      es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
      d    = el - es;
      dc   = (d > 8'd31) ? 5'd31 : d[4:0];
      ml   = {(lg[30:23] != 8'd0), lg[22:0], 3'b000};
      ms   = {5'd0, (sm[30:23] != 8'd0), sm[22:0], 3'b000};
      shd  = ms >> dc;
      mask = ~(32'hFFFFFFFF << dc);
      yal  = shd[26:0] | {26'd0, |(ms & mask)};
      if (lg[31] == sm[31]) begin
         sum_in  = {1'b0, ml} + {1'b0, yal};
         sign_in = lg[31];
      end else begin
         sum_in  = {1'b0, ml} - {1'b0, yal};
         // exact cancellation rounds to +0
         sign_in = (sum_in == 28'd0) ? 1'b0 : lg[31];
      end
      exp_in = el;
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         sign_ff  <= sign_in;
         exp_ff   <= exp_in;
         sum_ff   <= sum_in;
         nan_ff   <= nan_in;
         inf_ff   <= inf_in;
         isign_ff <= isign_in;
      end
   end

   always_comb begin
      logic [26:0] m;
      logic [9:0]  e;
      logic [4:0]  lz, sh;
      logic [7:0]  maxsh;
      logic [24:0] mr;
      logic [23:0] mant;
      logic        up;
      logic [9:0]  field;
      lz    = 5'd0;
      sh    = 5'd0;
      maxsh = 8'd0;
      if (sum_ff[27]) begin
         m = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         e = {2'b00, exp_ff} + 10'd1;
      end else begin
         lz    = fic_pkg::lzc27(sum_ff[26:0]);
         maxsh = exp_ff - 8'd1;
         // never shift below the minimum exponent, giving subnormals
         sh    = ({3'b000, lz} < maxsh) ? lz : maxsh[4:0];
         m     = sum_ff[26:0] << sh;
         e     = {2'b00, exp_ff} - {5'd0, sh};
      end
      up = m[2] & ((m[1] | m[0]) | m[3]);
      mr = {1'b0, m[26:3]} + {24'd0, up};
      if (mr[24]) begin
         mant = mr[24:1];
         e    = e + 10'd1;
      end else begin
         mant = mr[23:0];
      end
      field = mant[23] ? e : 10'd0;
      if (nan_ff) begin
         z_in = fic_pkg::QNAN_BITS;
      end else if (inf_ff) begin
         z_in = {isign_ff, fic_pkg::EXP_ONES, 23'd0};
      end else if (field >= 10'd255) begin
         z_in = {sign_ff, fic_pkg::EXP_ONES, 23'd0};
      end else begin
         z_in = {sign_ff, field[7:0], mant[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         z_ff <= z_in;
      end
   end

   assign z = z_ff;

endmodule

// ===== sv/fic_mul_unit.sv =====
// three-stage fp32 multiplier: mantissa product, normalize, denormalize and round
module fic_mul_unit (
   input  logic        clock,
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic        en_a,
   input  logic        en_b,
   input  logic        en_c,
   output logic [31:0] z
);

   logic        sign_a_ff, sign_a_in;
   logic [2:0]  spec_a_ff, spec_a_in;  // nan, inf, zero
   logic signed [10:0] exp_a_ff, exp_a_in;
   logic [47:0] prod_ff, prod_in;

   logic        sign_b_ff;
   logic [2:0]  spec_b_ff;
   logic signed [10:0] exp_b_ff, exp_b_in;
   logic [47:0] norm_ff, norm_in;

   logic [31:0] z_ff, z_in;

   always_comb begin
      logic xn, yn, xi, yi, xz, yz, nan, inf;
      logic [7:0] ex, ey;
      xn  = fic_pkg::is_nan(x);
      yn  = fic_pkg::is_nan(y);
      xi  = fic_pkg::is_inf(x);
      yi  = fic_pkg::is_inf(y);
      xz  = (x[30:0] == 31'd0);
      yz  = (y[30:0] == 31'd0);
      nan = xn || yn || (xi && yz) || (xz && yi);
      inf = (xi || yi) && !nan;
      spec_a_in = {nan, inf, (xz || yz) && !nan && !inf};
      sign_a_in = x[31] ^ y[31];
      ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      exp_a_in = $signed({3'b000, ex}) + $signed({3'b000, ey}) - 11'sd127;
      prod_in  = {(x[30:23] != 8'd0), x[22:0]} * {(y[30:23] != 8'd0), y[22:0]};
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         sign_a_ff <= sign_a_in;
         spec_a_ff <= spec_a_in;
         exp_a_ff  <= exp_a_in;
         prod_ff   <= prod_in;
      end
   end

   always_comb begin
      logic [5:0] lz;
      lz       = fic_pkg::lzc48(prod_ff);
      norm_in  = prod_ff << lz;
      exp_b_in = exp_a_ff + 11'sd1 - $signed({5'd0, lz});
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         sign_b_ff <= sign_a_ff;
         spec_b_ff <= spec_a_ff;
         exp_b_ff  <= exp_b_in;
         norm_ff   <= norm_in;
      end
   end

   always_comb begin
      logic [47:0] m, mask;
      logic signed [10:0] shift_ct;
      logic [5:0]  sh;
      logic        lost, up;
      logic [9:0]  e, field;
      logic [24:0] mr;
      logic [23:0] mant;
      shift_ct = 11'sd0;
      sh       = 6'd0;
      mask     = '0;
      if (exp_b_ff >= 11'sd1) begin
         m    = norm_ff;
         lost = 1'b0;
         e    = exp_b_ff[9:0];
      end else begin
         // below the normal range: shift into the subnormal position
         shift_ct = 11'sd1 - exp_b_ff;
         sh   = (shift_ct > 11'sd48) ? 6'd48 : shift_ct[5:0];
         m    = norm_ff >> sh;
         mask = ~({48{1'b1}} << sh);
         lost = |(norm_ff & mask);
         e    = 10'd1;
      end
      up = m[23] & ((|m[22:0]) | lost | m[24]);
      mr = {1'b0, m[47:24]} + {24'd0, up};
      if (mr[24]) begin
         mant = mr[24:1];
         e    = e + 10'd1;
      end else begin
         mant = mr[23:0];
      end
      field = mant[23] ? e : 10'd0;
      if (spec_b_ff[2]) begin
         z_in = fic_pkg::QNAN_BITS;
      end else if (spec_b_ff[1] || (field >= 10'd255)) begin
         z_in = {sign_b_ff, fic_pkg::EXP_ONES, 23'd0};
      end else if (spec_b_ff[0]) begin
         z_in = {sign_b_ff, 31'd0};
      end else begin
         z_in = {sign_b_ff, field[7:0], mant[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         z_ff <= z_in;
      end
   end

   assign z = z_ff;

endmodule

// ===== sv/fp32_isclose_comparator_core.sv =====
// top level of the fp32 closeness comparator: config registers and pipeline control
// Six-stage pipeline: one operand pair enters every cycle while req_stall is low, with stalls
// absorbed stage by stage so bubbles close up. Stage one aligns and adds a-b and forms the
// 24x24 mantissa product rtol*|b|; stage two rounds the difference and normalizes the
// product; stage three rounds the product; stages four and five add atol; stage six
// compares |a-b| against the bound and holds the flag for the consumer. Every operation
// rounds to nearest even and keeps subnormals. Tolerances must be written through the csr
// port only while no item is in flight; the block itself does not enforce this.
`include "fp32_isclose_comparator_core_macros.svh"

module fp32_isclose_comparator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_first_value,
   input  logic [31:0] req_second_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_close_flag
);

   logic [31:0] rtol_ff, atol_ff;
   logic        nan_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rtol_ff     <= fic_pkg::REL_TOLERANCE_RESET;
         atol_ff     <= fic_pkg::ABS_TOLERANCE_RESET;
         nan_mode_ff <= fic_pkg::NAN_EQUAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fic_pkg::CSR_REL_TOLERANCE:  rtol_ff     <= csr_write_data;
            fic_pkg::CSR_ABS_TOLERANCE:  atol_ff     <= csr_write_data;
            fic_pkg::CSR_NAN_EQUAL_MODE: nan_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // stage valids and per-stage advance
   logic [6:1] valid_ff, valid_in;
   logic [6:1] en;

   always_comb begin
      en[6] = !valid_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = req_valid;
      for (int k = 2; k <= 6; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign req_stall = !en[1];

   // early rules from the operands and csr settings
   fic_pkg::fic_early_type early_in;
   fic_pkg::fic_early_type early_ff [1:5];

   always_comb begin
      logic a_nan, b_nan, equal;
      a_nan = fic_pkg::is_nan(req_first_value);
      b_nan = fic_pkg::is_nan(req_second_value);
      equal = ((req_first_value[30:0] == 31'd0) && (req_second_value[30:0] == 31'd0))
              || ((req_first_value == req_second_value) && !a_nan);
      priority if (equal || (nan_mode_ff && a_nan && b_nan)) begin
         early_in = fic_pkg::EARLY_CLOSE;
      end else if ((rtol_ff[30:0] == 31'd0) && (atol_ff[30:0] == 31'd0)) begin
         early_in = fic_pkg::EARLY_FAR;
      end else begin
         early_in = fic_pkg::EARLY_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) early_ff[1] <= early_in;
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) early_ff[k] <= early_ff[k-1];
      end
   end

   logic [31:0] diff, scaled, bound;
   logic [30:0] diff3_ff, diff4_ff, diff5_ff;

   fic_add_unit u_diff (
      .clock (clock),
      .x     (req_first_value),
      .y     (req_second_value),
      .sub   (1'b1),
      .en_a  (en[1]),
      .en_b  (en[2]),
      .z     (diff)
   );

   fic_mul_unit u_scale (
      .clock (clock),
      .x     (rtol_ff),
      .y     ({1'b0, req_second_value[30:0]}),
      .en_a  (en[1]),
      .en_b  (en[2]),
      .en_c  (en[3]),
      .z     (scaled)
   );

   fic_add_unit u_bound (
      .clock (clock),
      .x     (atol_ff),
      .y     (scaled),
      .sub   (1'b0),
      .en_a  (en[4]),
      .en_b  (en[5]),
      .z     (bound)
   );

   always_ff @(posedge clock) begin
      if (en[3]) diff3_ff <= diff[30:0];
      if (en[4]) diff4_ff <= diff3_ff;
      if (en[5]) diff5_ff <= diff4_ff;
   end

   logic close_ff, close_in;

   always_comb begin
      logic cmp;
      if ((diff5_ff[30:23] == fic_pkg::EXP_ONES) || fic_pkg::is_nan(bound)) begin
         cmp = 1'b0;
      end else if (bound[31]) begin
         cmp = (diff5_ff == 31'd0) && (bound[30:0] == 31'd0);
      end else begin
         cmp = (diff5_ff <= bound[30:0]);
      end
      unique case (early_ff[5])
         fic_pkg::EARLY_CLOSE: close_in = 1'b1;
         fic_pkg::EARLY_FAR:   close_in = 1'b0;
         default:              close_in = cmp;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[6]) close_ff <= close_in;
   end

   assign rsp_valid      = valid_ff[6];
   assign rsp_close_flag = close_ff;

   // item leaving stage five, and which early rule it carries
   logic move_out, out_close, out_far;
   assign move_out  = valid_ff[5] && en[6];
   assign out_close = move_out && (early_ff[5] == fic_pkg::EARLY_CLOSE);
   assign out_far   = move_out && (early_ff[5] == fic_pkg::EARLY_FAR);

   `FIC_ASSERT(a_accept_enters, (req_valid && !req_stall) |=> valid_ff[1], "accepted item lost")
   `FIC_ASSERT_NEXT(a_drain_moves, move_out, rsp_valid, "stage five item not delivered")
   `FIC_ASSERT_NEXT(a_early_close, out_close, rsp_close_flag, "equal operands not flagged close")
   `FIC_ASSERT_NEXT(a_early_far, out_far, !rsp_close_flag, "zero tolerance flagged close")

endmodule
